[rtl/owpu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry pose update package
// Widths, fixed-point constants, codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package owpu_pkg;

  localparam int TICK_BITS    = 16;
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;

  localparam int REQ_W      = 2;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 3;
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 18;

  localparam int SUM_W     = TICK_BITS + 1;
  localparam int MAG_W     = TICK_BITS + 1;
  localparam int MUL_A_W   = 48;
  localparam int MUL_B_W   = 25;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int P_W       = 46;
  localparam int RSHIFT    = 33 - FRAC_BITS;
  localparam int ANG_W     = 33;
  localparam int Z_W       = 36;
  localparam int CX_W      = 52;
  localparam int STEP_W    = 5;

  localparam logic signed [MUL_P_W-1:0] P_HI = MUL_P_W'((64'sd1 <<< 45) - 64'sd1);
  localparam logic signed [MUL_P_W-1:0] P_LO = -P_HI;
  localparam logic signed [MUL_A_W-1:0] GAIN_Q30    = 48'sd652032874;
  localparam logic [ANG_W:0]            TWO_PI_Q30  = 34'd6746518852;
  localparam logic [ANG_W:0]            PI_Q30      = 34'd3373259426;
  localparam logic [ANG_W:0]            HALF_PI_Q30 = 34'd1686629713;

  typedef enum logic [REQ_W-1:0] {
    REQ_FULL,
    REQ_TRANS,
    REQ_ROT
  } req_t;

  typedef enum logic {
    REG_DIST_PER_TICK,
    REG_ANGLE_PER_TICK
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_DIST_GO,
    ST_T_DIST_WT,
    ST_T_X_GO,
    ST_T_X_WT,
    ST_T_Y_GO,
    ST_T_Y_WT,
    ST_R_MOD_GO,
    ST_R_MOD_WT,
    ST_R_GX_GO,
    ST_R_GX_WT,
    ST_R_GY_GO,
    ST_R_GY_WT,
    ST_R_COR_GO,
    ST_R_COR_WT,
    ST_RESULT
  } state_t;

  // Arctangent of 2^-i in Q30 radians.
  function automatic logic [31:0] atan_q30(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd843314857;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043837;
      5'd3:    v = 32'd133525159;
      5'd4:    v = 32'd67021687;
      5'd5:    v = 32'd33543516;
      5'd6:    v = 32'd16775851;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194283;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048576;
      5'd11:   v = 32'd524288;
      5'd12:   v = 32'd262144;
      5'd13:   v = 32'd131072;
      5'd14:   v = 32'd65536;
      5'd15:   v = 32'd32768;
      5'd16:   v = 32'd16384;
      5'd17:   v = 32'd8192;
      5'd18:   v = 32'd4096;
      5'd19:   v = 32'd2048;
      5'd20:   v = 32'd1024;
      5'd21:   v = 32'd512;
      5'd22:   v = 32'd256;
      5'd23:   v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/owpu_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder reading channel
// Valid/ready channel carrying one request type and two wheel tick counts.
// ----------------------------------------------------------------------------
interface owpu_in_if;
  import owpu_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [REQ_W-1:0]            req_type;
  logic signed [TICK_BITS-1:0] left_ticks;
  logic signed [TICK_BITS-1:0] right_ticks;
  modport source (output valid, req_type, left_ticks, right_ticks, input ready);
  modport sink (input valid, req_type, left_ticks, right_ticks, output ready);
endinterface

[rtl/owpu_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose result channel
// Valid/ready channel carrying the position and heading vector.
// ----------------------------------------------------------------------------
interface owpu_out_if;
  import owpu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HEAD_W-1:0] heading_cos;
  logic signed [HEAD_W-1:0] heading_sin;
  modport source (output valid, pos_x, pos_y, heading_cos, heading_sin, input ready);
  modport sink (input valid, pos_x, pos_y, heading_cos, heading_sin, output ready);
endinterface

[rtl/owpu_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Consumes one bit of the multiplier per cycle, LSB first; the top bit
// carries negative weight.
// ----------------------------------------------------------------------------
module owpu_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [owpu_pkg::MUL_A_W-1:0] a,
  input  logic signed [owpu_pkg::MUL_B_W-1:0] b,
  output logic                                done,
  output logic signed [owpu_pkg::MUL_P_W-1:0] prod
);
  import owpu_pkg::*;

  localparam int CNT_W = $clog2(MUL_B_W);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [MUL_P_W-1:0] a_sh_r;
  logic signed [MUL_P_W-1:0] acc_r;
  logic signed [MUL_P_W-1:0] acc_nxt;
  logic [MUL_B_W-1:0]        b_sh_r;
  logic                      last;

  assign last = (cnt_r == CNT_W'(MUL_B_W - 1));

  always_comb begin
    acc_nxt = acc_r;
    if (b_sh_r[0]) begin
      acc_nxt = last ? (acc_r - a_sh_r) : (acc_r + a_sh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= MUL_P_W'(a);
      b_sh_r <= b;
      acc_r  <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      a_sh_r <= a_sh_r <<< 1;
      b_sh_r <= b_sh_r >> 1;
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/owpu_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial angle reduction
// Forms mag * angle_per_tick * 32 modulo 2*pi (Q30), one bit of the
// magnitude per cycle, MSB first, keeping the partial result reduced.
// ----------------------------------------------------------------------------
module owpu_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [owpu_pkg::MAG_W-1:0]  mag,
  input  logic [owpu_pkg::CFG_W-1:0]  apt,
  output logic                        done,
  output logic [owpu_pkg::ANG_W-1:0]  ang
);
  import owpu_pkg::*;

  localparam int CNT_W = $clog2(MAG_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0] mag_sh_r;
  logic [CFG_W-1:0] apt_r;
  logic [ANG_W-1:0] acc_r;
  logic [ANG_W:0]   dbl;
  logic [ANG_W:0]   dbl_red;
  logic [ANG_W:0]   sum;
  logic [ANG_W:0]   sum_red;
  logic             last;

  assign last = (cnt_r == CNT_W'(MAG_W - 1));

  // Both partial values stay below twice the modulus, so one subtract each.
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= TWO_PI_Q30) ? (dbl - TWO_PI_Q30) : dbl;
    sum     = dbl_red;
    if (mag_sh_r[MAG_W-1]) begin
      sum = dbl_red + (ANG_W + 1)'({apt_r, 5'b0});
    end
    sum_red = (sum >= TWO_PI_Q30) ? (sum - TWO_PI_Q30) : sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_sh_r <= mag;
      apt_r    <= apt;
      acc_r    <= '0;
      cnt_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= sum_red[ANG_W-1:0];
      mag_sh_r <= mag_sh_r << 1;
      cnt_r    <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign ang  = acc_r;

endmodule

[rtl/owpu_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative CORDIC rotator
// One micro-rotation per cycle with arithmetic shifts and a Q30 angle table.
// ----------------------------------------------------------------------------
module owpu_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [owpu_pkg::CX_W-1:0] x0,
  input  logic signed [owpu_pkg::CX_W-1:0] y0,
  input  logic signed [owpu_pkg::Z_W-1:0]  z0,
  output logic                             done,
  output logic signed [owpu_pkg::CX_W-1:0] x,
  output logic signed [owpu_pkg::CX_W-1:0] y
);
  import owpu_pkg::*;

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      cnt_r;
  logic signed [CX_W-1:0] x_r;
  logic signed [CX_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  logic signed [CX_W-1:0] dx;
  logic signed [CX_W-1:0] dy;
  logic signed [Z_W-1:0]  at;
  logic                   last;

  assign last = (cnt_r == STEP_W'(CORDIC_STEPS - 1));
  assign dx   = y_r >>> cnt_r;
  assign dy   = x_r >>> cnt_r;
  assign at   = $signed(Z_W'(atan_q30(cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (!z_r[Z_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;

endmodule

[rtl/wheel_odometry_pose_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel odometry pose update
// Translates the position along the heading and rotates the heading vector
// from one encoder reading, using a shared bit-serial multiplier, a serial
// angle reduction and an iterative CORDIC.
//
//   Channel  | Direction | Payload
//   in_ch    | in        | req_type, left_ticks, right_ticks
//   out_ch   | out       | pos_x, pos_y, heading_cos, heading_sin
//   cfg_*    | in/out    | APB registers dist_per_tick, angle_per_tick
//
// A full update takes five products from the serial multiplier (one multiplier
// bit per cycle), which sets most of its time; translate only and rotate only
// run part of the sequence, and an unused request type goes straight to result.
// One request is processed at a time; the next is taken once the result sits
// in the output register, even while that register is still stalled.
// Reset is synchronous and returns the pose to origin with heading (1, 0).
// ----------------------------------------------------------------------------
module wheel_odometry_pose_update (
  input  logic                              clk,
  input  logic                              rst_n,
  owpu_in_if.sink                           in_ch,
  owpu_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [owpu_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import owpu_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]            dpt_r;
  logic [CFG_W-1:0]            apt_r;
  logic [REQ_W-1:0]            req_r;
  logic signed [TICK_BITS-1:0] l_r;
  logic signed [TICK_BITS-1:0] r_r;
  logic signed [POS_W-1:0]     x_acc_r;
  logic signed [POS_W-1:0]     y_acc_r;
  logic signed [HEAD_W-1:0]    head_c_r;
  logic signed [HEAD_W-1:0]    head_s_r;
  logic signed [P_W-1:0]       p_r;
  logic signed [Z_W-1:0]       z_r;
  logic                        flip_r;
  logic signed [CX_W-1:0]      cx_r;
  logic signed [CX_W-1:0]      cy_r;
  logic                        out_valid_r;
  logic signed [POS_W-1:0]     out_x_r;
  logic signed [POS_W-1:0]     out_y_r;
  logic signed [HEAD_W-1:0]    out_c_r;
  logic signed [HEAD_W-1:0]    out_s_r;

  logic                        cfg_wr;
  logic                        mul_start;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic                        mul_done;
  logic signed [MUL_P_W-1:0]   mul_prod;
  logic                        mod_start;
  logic                        mod_done;
  logic [ANG_W-1:0]            mod_ang;
  logic                        cor_start;
  logic                        cor_done;
  logic signed [CX_W-1:0]      cor_x;
  logic signed [CX_W-1:0]      cor_y;
  logic                        in_ready;
  logic                        out_load;

  logic signed [SUM_W-1:0]     tick_sum;
  logic [MAG_W-1:0]            tick_mag;
  logic signed [P_W-1:0]       p_clamped;
  logic signed [MUL_P_W-1:0]   step_rnd;
  logic signed [POS_W-1:0]     x_new;
  logic signed [POS_W-1:0]     y_new;
  logic signed [Z_W-1:0]       zs0;
  logic signed [Z_W-1:0]       zs1;
  logic signed [Z_W-1:0]       z_fold;
  logic                        flip;
  logic signed [CX_W-1:0]      gain_v;
  logic signed [HEAD_W-1:0]    hc_new;
  logic signed [HEAD_W-1:0]    hs_new;

  localparam logic signed [MUL_P_W-1:0] RND_T = MUL_P_W'(1) <<< (RSHIFT - 1);
  localparam logic signed [CX_W-1:0]    RND_H = CX_W'(1) <<< 29;
  localparam logic signed [Z_W-1:0]     PI_S   = $signed(Z_W'(PI_Q30));
  localparam logic signed [Z_W-1:0]     HALF_S = $signed(Z_W'(HALF_PI_Q30));
  localparam logic signed [Z_W-1:0]     TWO_S  = $signed(Z_W'(TWO_PI_Q30));

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [MUL_P_W:0] v);
    logic signed [POS_W-1:0] res;
    if ((&v[MUL_P_W:POS_W-1]) || !(|v[MUL_P_W:POS_W-1])) begin
      res = v[POS_W-1:0];
    end else begin
      res = v[MUL_P_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic signed [HEAD_W-1:0] head_out(input logic signed [CX_W-1:0] v);
    logic signed [CX_W-1:0]   rv;
    logic signed [HEAD_W-1:0] res;
    rv = (v + RND_H) >>> 30;
    if ((&rv[CX_W-1:HEAD_W-1]) || !(|rv[CX_W-1:HEAD_W-1])) begin
      res = rv[HEAD_W-1:0];
    end else begin
      res = rv[CX_W-1] ? {1'b1, {(HEAD_W-1){1'b0}}} : {1'b0, {(HEAD_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Configuration registers.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_reg_t'(cfg_paddr[2]))
      REG_DIST_PER_TICK:  cfg_prdata = {8'b0, dpt_r};
      REG_ANGLE_PER_TICK: cfg_prdata = {8'b0, apt_r};
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpt_r <= 24'd65536;
      apt_r <= 24'd1677722;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_paddr[2]))
        REG_DIST_PER_TICK:  dpt_r <= cfg_pwdata[CFG_W-1:0];
        REG_ANGLE_PER_TICK: apt_r <= cfg_pwdata[CFG_W-1:0];
        default:            dpt_r <= dpt_r;
      endcase
    end
  end

  // Arithmetic around the serial units.
  always_comb begin
    tick_sum = SUM_W'(l_r) + SUM_W'(r_r);
    tick_mag = MAG_W'(l_r[TICK_BITS-1] ? -SUM_W'(l_r) : SUM_W'(l_r))
             + MAG_W'(r_r[TICK_BITS-1] ? -SUM_W'(r_r) : SUM_W'(r_r));

    if (mul_prod > P_HI) begin
      p_clamped = P_W'(P_HI);
    end else if (mul_prod < P_LO) begin
      p_clamped = P_W'(P_LO);
    end else begin
      p_clamped = P_W'(mul_prod);
    end

    step_rnd = (mul_prod + RND_T) >>> RSHIFT;
    x_new    = sat_pos((MUL_P_W + 1)'(x_acc_r) + (MUL_P_W + 1)'(step_rnd));
    y_new    = sat_pos((MUL_P_W + 1)'(y_acc_r) + (MUL_P_W + 1)'(step_rnd));

    // Map the reduced angle to (-pi, pi], set the turn direction, and fold
    // angles beyond a quarter turn by negating the start vector.
    zs0 = (Z_W'(mod_ang) > Z_W'(PI_Q30)) ? ($signed(Z_W'(mod_ang)) - TWO_S)
                                         : $signed(Z_W'(mod_ang));
    zs1 = ($signed(r_r) > $signed(l_r)) ? zs0 : -zs0;
    flip   = 1'b0;
    z_fold = zs1;
    if (zs1 > HALF_S) begin
      flip   = 1'b1;
      z_fold = zs1 - PI_S;
    end else if (zs1 < -HALF_S) begin
      flip   = 1'b1;
      z_fold = zs1 + PI_S;
    end

    gain_v = flip_r ? -CX_W'(mul_prod) : CX_W'(mul_prod);
    hc_new = head_out(cor_x);
    hs_new = head_out(cor_y);
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.req_type)
            REQ_FULL:  state_nxt = ST_T_DIST_GO;
            REQ_TRANS: state_nxt = ST_T_DIST_GO;
            REQ_ROT:   state_nxt = ST_R_MOD_GO;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_T_DIST_GO: state_nxt = ST_T_DIST_WT;
      ST_T_DIST_WT: if (mul_done) state_nxt = ST_T_X_GO;
      ST_T_X_GO:    state_nxt = ST_T_X_WT;
      ST_T_X_WT:    if (mul_done) state_nxt = ST_T_Y_GO;
      ST_T_Y_GO:    state_nxt = ST_T_Y_WT;
      ST_T_Y_WT: begin
        if (mul_done) begin
          state_nxt = (req_r == REQ_FULL) ? ST_R_MOD_GO : ST_RESULT;
        end
      end
      ST_R_MOD_GO:  state_nxt = ST_R_MOD_WT;
      ST_R_MOD_WT:  if (mod_done) state_nxt = ST_R_GX_GO;
      ST_R_GX_GO:   state_nxt = ST_R_GX_WT;
      ST_R_GX_WT:   if (mul_done) state_nxt = ST_R_GY_GO;
      ST_R_GY_GO:   state_nxt = ST_R_GY_WT;
      ST_R_GY_WT:   if (mul_done) state_nxt = ST_R_COR_GO;
      ST_R_COR_GO:  state_nxt = ST_R_COR_WT;
      ST_R_COR_WT:  if (cor_done) state_nxt = ST_RESULT;
      ST_RESULT:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mod_start = 1'b0;
    cor_start = 1'b0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:      in_ready = 1'b1;
      ST_T_DIST_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(tick_sum);
        mul_b     = $signed({1'b0, dpt_r});
      end
      ST_T_X_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(p_r);
        mul_b     = MUL_B_W'(head_c_r);
      end
      ST_T_Y_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(p_r);
        mul_b     = MUL_B_W'(head_s_r);
      end
      ST_R_MOD_GO:  mod_start = 1'b1;
      ST_R_GX_GO: begin
        mul_start = 1'b1;
        mul_a     = GAIN_Q30;
        mul_b     = MUL_B_W'(head_c_r);
      end
      ST_R_GY_GO: begin
        mul_start = 1'b1;
        mul_a     = GAIN_Q30;
        mul_b     = MUL_B_W'(head_s_r);
      end
      ST_R_COR_GO:  cor_start = 1'b1;
      ST_RESULT:    out_load = !out_valid_r || out_ch.ready;
      default:      in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      head_c_r    <= 18'sd65536;
      head_s_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_T_X_WT && mul_done) begin
        x_acc_r <= x_new;
      end
      if (state_r == ST_T_Y_WT && mul_done) begin
        y_acc_r <= y_new;
      end
      if (state_r == ST_R_COR_WT && cor_done) begin
        head_c_r <= hc_new;
        head_s_r <= hs_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) begin
      req_r <= in_ch.req_type;
      l_r   <= in_ch.left_ticks;
      r_r   <= in_ch.right_ticks;
    end
    if (state_r == ST_T_DIST_WT && mul_done) begin
      p_r <= p_clamped;
    end
    if (state_r == ST_R_MOD_WT && mod_done) begin
      z_r    <= z_fold;
      flip_r <= flip;
    end
    if (state_r == ST_R_GX_WT && mul_done) begin
      cx_r <= gain_v;
    end
    if (state_r == ST_R_GY_WT && mul_done) begin
      cy_r <= gain_v;
    end
    if (out_load) begin
      out_x_r <= x_acc_r;
      out_y_r <= y_acc_r;
      out_c_r <= head_c_r;
      out_s_r <= head_s_r;
    end
  end

  owpu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  owpu_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .mag   (tick_mag),
    .apt   (apt_r),
    .done  (mod_done),
    .ang   (mod_ang)
  );

  owpu_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x0    (cx_r),
    .y0    (cy_r),
    .z0    (z_r),
    .done  (cor_done),
    .x     (cor_x),
    .y     (cor_y)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x       = out_x_r;
  assign out_ch.pos_y       = out_y_r;
  assign out_ch.heading_cos = out_c_r;
  assign out_ch.heading_sin = out_s_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_ch.valid) |=> (state_r != ST_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_load_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result raised outside the result state");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && out_valid_r && !out_ch.ready) |=> (state_r == ST_RESULT))
    else $error("new result dropped while output stalled");

  a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ch.ready)
    else $error("input ready while a request is in progress");
`endif

endmodule
